/* sv/tbdg_pkg.sv */
// Package for the two-button debounce and gesture block.
// Holds the word types, configuration register indexes, reset values and
// the per-button status struct. No dependencies.
`default_nettype none

package tbdg_pkg;

    localparam int TICK_WIDTH_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd5;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd50;

    typedef struct packed {
        logic raw_a;
        logic raw_b;
        logic alarm_on;
    } in_word_t;

    typedef struct packed {
        logic held_a;
        logic held_b;
        logic activity;
        logic mode_toggle;
        logic combo_event;
        logic alarm_cancel;
        logic sleep_request;
    } out_word_t;

    typedef struct packed {
        logic press;
        logic release_ev;
        logic level;
    } db_status_t;

endpackage

`default_nettype wire

/* sv/tbdg_debounce.sv */
// Debouncer for one active-low button: raw level tracker, saturating age
// counter and stable level. Depends on tbdg_pkg.
`default_nettype none

module tbdg_debounce
    import tbdg_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             raw,
    input  wire logic [CFG_W-1:0] debounce_ticks,
    output db_status_t            status
);

    localparam int CW = TICK_WIDTH + CFG_W;

    logic                  last_raw_reg, last_raw_next;
    logic                  stable_reg, stable_next;
    logic [TICK_WIDTH-1:0] age_reg, age_next, age_inc;

    always_comb begin
        age_inc       = (age_reg == {TICK_WIDTH{1'b1}}) ? age_reg
                                                        : age_reg + TICK_WIDTH'(1);
        last_raw_next = raw;
        stable_next   = stable_reg;
        status        = '0;
        if (raw != last_raw_reg) begin
            age_next = '0;
        end else begin
            age_next = age_inc;
            if ((CW'(age_inc) >= CW'(debounce_ticks)) && (raw != stable_reg)) begin
                stable_next       = raw;
                status.press      = ~raw;
                status.release_ev = raw;
            end
        end
        status.level = stable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg <= 1'b1;
            stable_reg   <= 1'b1;
            age_reg      <= '0;
        end else if (en) begin
            last_raw_reg <= last_raw_next;
            stable_reg   <= stable_next;
            age_reg      <= age_next;
        end
    end

endmodule

`default_nettype wire

/* sv/tbdg_gesture.sv */
// Gesture logic: B hold timer, long-press release, combo and solo-A pulses.
// Depends on tbdg_pkg and the status of both debouncers.
`default_nettype none

module tbdg_gesture
    import tbdg_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire db_status_t       db_a,
    input  wire db_status_t       db_b,
    input  wire logic             alarm_on,
    input  wire logic [CFG_W-1:0] long_press_ticks,
    output out_word_t             result
);

    localparam int CW = TICK_WIDTH + CFG_W;

    logic [TICK_WIDTH-1:0] hold_age_reg, hold_age_next, hold_inc;
    logic                  long_done_reg, long_done_next;
    logic                  prev_both_reg, prev_a_reg;
    logic                  held_a, held_b, both;

    always_comb begin
        hold_inc       = (hold_age_reg == {TICK_WIDTH{1'b1}}) ? hold_age_reg
                                                               : hold_age_reg + TICK_WIDTH'(1);
        hold_age_next  = hold_inc;
        long_done_next = long_done_reg;
        held_a         = ~db_a.level;
        held_b         = ~db_b.level;
        both           = held_a & held_b;
        result         = '0;
        result.held_a  = held_a;
        result.held_b  = held_b;
        result.activity = db_a.press | db_b.press;
        if (db_b.press) begin
            hold_age_next  = '0;
            long_done_next = 1'b0;
        end else if (db_b.release_ev && !long_done_reg) begin
            if ((CW'(hold_inc) >= CW'(long_press_ticks)) && db_a.level) begin
                result.mode_toggle = 1'b1;
                long_done_next     = 1'b1;
            end
        end
        result.combo_event = both & ~prev_both_reg;
        if (held_a && !prev_a_reg && !held_b) begin
            result.alarm_cancel  = alarm_on;
            result.sleep_request = ~alarm_on;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_age_reg  <= '0;
            long_done_reg <= 1'b0;
            prev_both_reg <= 1'b0;
            prev_a_reg    <= 1'b0;
        end else if (en) begin
            hold_age_reg  <= hold_age_next;
            long_done_reg <= long_done_next;
            prev_both_reg <= both;
            prev_a_reg    <= held_a;
        end
    end

endmodule

`default_nettype wire

/* sv/two_button_debounce_gesture.sv */
// Top level of the two-button debounce and gesture block: input register,
// configuration registers, result register. Depends on tbdg_pkg,
// tbdg_debounce and tbdg_gesture.
//
//  channel | ports                               | word
//  --------+-------------------------------------+-----------------------------
//  input   | s_valid, s_ready, s_word            | in_word_t, one tick sample
//  result  | m_valid, m_ready, m_word            | out_word_t, one per tick
//  config  | cfg_wr_en, cfg_index, cfg_wdata     | 16-bit register write
//
// Each tick word passes through the input register, then the result register;
// one word per cycle is sustained while the receiver keeps m_ready high.
// The input register refills in the cycle it drains, so a waiting result does
// not stop intake until both registers are full.
// Synchronous active-low reset restores the released button state and the
// register defaults (debounce 5, long press 50).
`default_nettype none

module two_button_debounce_gesture
    import tbdg_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_word_t             s_word,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_word_t                 m_word,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    logic             in_valid_reg, in_valid_next;
    in_word_t         in_word_reg;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_word_reg;
    logic [CFG_W-1:0] debounce_reg, long_press_reg;
    logic             advance;
    db_status_t       db_a, db_b;
    out_word_t        result;

    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;
    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    tbdg_debounce #(.TICK_WIDTH(TICK_WIDTH)) u_db_a (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (advance),
        .raw            (in_word_reg.raw_a),
        .debounce_ticks (debounce_reg),
        .status         (db_a)
    );

    tbdg_debounce #(.TICK_WIDTH(TICK_WIDTH)) u_db_b (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (advance),
        .raw            (in_word_reg.raw_b),
        .debounce_ticks (debounce_reg),
        .status         (db_b)
    );

    tbdg_gesture #(.TICK_WIDTH(TICK_WIDTH)) u_gesture (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (advance),
        .db_a             (db_a),
        .db_b             (db_b),
        .alarm_on         (in_word_reg.alarm_on),
        .long_press_ticks (long_press_reg),
        .result           (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                    REG_LONG_PRESS: long_press_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
        if (advance) begin
            out_word_reg <= result;
        end
    end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for two_button_debounce_gesture: tick words in, one
// predicted output word per tick, compared field by field as results drain.
// Depends on tbdg_pkg and the two_button_debounce_gesture RTL.
`default_nettype none

module tb_top
    import tbdg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE_TICKS = 6;
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        DB_NONE,
        DB_PRESSED,
        DB_RELEASED
    } db_event_e;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_word_t             s_word = '1;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_word_t            m_word;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // button model state and its copy of the registers
    logic [15:0] debounce_reg;
    logic [15:0] long_press_reg;
    logic [1:0]  last_raw_q;
    logic [1:0]  stable_q;
    logic [15:0] unchanged_q [2];
    logic [15:0] hold_b_q;
    logic        long_done_q;
    logic        prev_both_q;
    logic        prev_a_q;

    out_word_t button_outputs_due [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int error_count = 0;

    two_button_debounce_gesture dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == TICK_MAX) ? TICK_MAX : v + 16'd1;
    endfunction

    function automatic db_event_e step_debouncer(int k, logic raw);
        if (raw != last_raw_q[k]) begin
            last_raw_q[k] = raw;
            unchanged_q[k] = '0;
            return DB_NONE;
        end
        unchanged_q[k] = sat_inc(unchanged_q[k]);
        if (unchanged_q[k] >= debounce_reg && raw != stable_q[k]) begin
            stable_q[k] = raw;
            return raw ? DB_RELEASED : DB_PRESSED;
        end
        return DB_NONE;
    endfunction

    function automatic out_word_t next_button_outputs(in_word_t w);
        out_word_t o;
        db_event_e ev_a;
        db_event_e ev_b;
        logic both;
        o = '0;
        hold_b_q = sat_inc(hold_b_q);
        ev_a = step_debouncer(0, w.raw_a);
        if (ev_a == DB_PRESSED) o.activity = 1'b1;
        ev_b = step_debouncer(1, w.raw_b);
        if (ev_b == DB_PRESSED) begin
            o.activity = 1'b1;
            hold_b_q = '0;
            long_done_q = 1'b0;
        end else if (ev_b == DB_RELEASED && !long_done_q) begin
            if (hold_b_q >= long_press_reg && stable_q[0]) begin
                o.mode_toggle = 1'b1;
                long_done_q = 1'b1;
            end
        end
        o.held_a = !stable_q[0];
        o.held_b = !stable_q[1];
        both = o.held_a && o.held_b;
        o.combo_event = both && !prev_both_q;
        prev_both_q = both;
        if (o.held_a && !prev_a_q && !o.held_b) begin
            o.alarm_cancel = w.alarm_on;
            o.sleep_request = !w.alarm_on;
        end
        prev_a_q = o.held_a;
        return o;
    endfunction

    task automatic reset_button_model();
        debounce_reg = DEBOUNCE_RESET;
        long_press_reg = LONG_PRESS_RESET;
        last_raw_q = 2'b11;
        stable_q = 2'b11;
        unchanged_q[0] = '0;
        unchanged_q[1] = '0;
        hold_b_q = '0;
        long_done_q = 1'b0;
        prev_both_q = 1'b0;
        prev_a_q = 1'b0;
    endtask

    task automatic report_failure(string what);
        $display("error at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic send_word(in_word_t w);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        button_outputs_due.push_back(next_button_outputs(w));
        ticks_sent++;
    endtask

    task automatic tick(logic a, logic b, logic alarm);
        in_word_t w;
        w.raw_a = a;
        w.raw_b = b;
        w.alarm_on = alarm;
        send_word(w);
    endtask

    task automatic hold_levels(logic a, logic b, int n);
        for (int i = 0; i < n; i++) tick(a, b, 1'($urandom_range(1)));
    endtask

    // drop valid, drain every pending result, then let the pipeline empty
    task automatic settle_block();
        s_valid <= 1'b0;
        while (button_outputs_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic configure(logic [15:0] db, logic [15:0] lp);
        settle_block();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_wdata <= db;
        @(posedge aclk);
        debounce_reg = db;
        cfg_index <= REG_LONG_PRESS;
        cfg_wdata <= lp;
        @(posedge aclk);
        long_press_reg = lp;
        cfg_wr_en <= 1'b0;
        reg_writes += 2;
    endtask

    task automatic random_gesture();
        int len;
        int pre;
        logic first_a;
        len = debounce_reg + $urandom_range(1, 4);
        case ($urandom_range(9))
            0, 1: begin
                for (int i = $urandom_range(3); i > 0; i--)
                    tick(1'($urandom_range(1)), 1'b1, 1'b0);
                hold_levels(1'b0, 1'b1, len);
                for (int i = $urandom_range(3); i > 0; i--)
                    tick(1'($urandom_range(1)), 1'b1, 1'b1);
                hold_levels(1'b1, 1'b1, len);
            end
            2, 3, 4: begin
                for (int i = $urandom_range(3); i > 0; i--)
                    tick(1'b1, 1'($urandom_range(1)), 1'b0);
                hold_levels(1'b1, 1'b0, debounce_reg + $urandom_range(0, long_press_reg + 4));
                for (int i = $urandom_range(2); i > 0; i--)
                    tick(1'b1, 1'($urandom_range(1)), 1'b1);
                hold_levels(1'b1, 1'b1, len);
            end
            5, 6: begin
                pre = $urandom_range(3);
                first_a = 1'($urandom_range(1));
                hold_levels(!first_a, first_a, pre);
                hold_levels(1'b0, 1'b0, len + $urandom_range(long_press_reg));
                hold_levels(first_a, !first_a, $urandom_range(debounce_reg + 3));
                hold_levels(1'b1, 1'b1, len);
            end
            7: begin
                hold_levels(1'b1, 1'b0, len);
                hold_levels(1'b0, 1'b0, len + $urandom_range(long_press_reg));
                hold_levels(1'b0, 1'b1, len);
                hold_levels(1'b1, 1'b1, len);
            end
            default: begin
                for (int i = $urandom_range(4, 16); i > 0; i--) begin
                    tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
                end
            end
        endcase
    endtask

    task automatic test_reset_defaults();
        hold_levels(1'b0, 1'b1, 8);
        hold_levels(1'b1, 1'b1, 8);
        hold_levels(1'b1, 1'b0, 58);
        hold_levels(1'b1, 1'b1, 8);
    endtask

    task automatic test_directed_gestures();
        configure(16'd0, 16'd0);
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b0, 1'b1, 1'b1);
        tick(1'b0, 1'b1, 1'b1);
        tick(1'b1, 1'b1, 1'b0);
        tick(1'b1, 1'b1, 1'b0);
        tick(1'b0, 1'b1, 1'b0);
        tick(1'b0, 1'b1, 1'b0);
        tick(1'b1, 1'b1, 1'b0);
        tick(1'b1, 1'b1, 1'b0);
        tick(1'b0, 1'b0, 1'b0);
        tick(1'b0, 1'b0, 1'b0);
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b1, 1'b0, 1'b0);
        tick(1'b1, 1'b0, 1'b0);
        tick(1'b1, 1'b1, 1'b0);
        tick(1'b1, 1'b1, 1'b0);
        // release B while A is held: no toggle
        tick(1'b0, 1'b1, 1'b0);
        tick(1'b0, 1'b1, 1'b0);
        tick(1'b0, 1'b0, 1'b1);
        tick(1'b0, 1'b0, 1'b1);
        tick(1'b0, 1'b1, 1'b1);
        tick(1'b0, 1'b1, 1'b1);
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        configure(16'd1, 16'd3);
        idle_pct = 0;
        stall_pct = 0;
        hold_req <= hold_req + 1;
        for (int i = 0; i < 40; i++) begin
            tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_random_phases();
        int idle_set [4] = '{0, 72, 0, 22};
        int stall_set [4] = '{0, 0, 72, 22};
        int target;
        logic [15:0] db;
        logic [15:0] lp;
        for (int p = 0; p < 4; p++) begin
            for (int c = 0; c < 2; c++) begin
                case ($urandom_range(3))
                    0: db = 16'd0;
                    1: db = 16'd1;
                    default: db = 16'($urandom_range(2, 6));
                endcase
                lp = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 20));
                configure(db, lp);
                idle_pct = idle_set[p];
                stall_pct = stall_set[p];
                target = ticks_sent + 140;
                while (ticks_sent < target) random_gesture();
            end
        end
    endtask

    task automatic test_large_thresholds();
        configure(TICK_MAX, TICK_MAX);
        idle_pct = 0;
        stall_pct = 0;
        hold_levels(1'b1, 1'b0, 20);
        hold_levels(1'b1, 1'b1, 20);
        hold_levels(1'b0, 1'b1, 4);
    endtask

    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (button_outputs_due.size() == 0) begin
                report_failure("result word with nothing pending");
            end else begin
                want = button_outputs_due.pop_front();
                if (m_word.held_a !== want.held_a)
                    report_failure($sformatf("held_a got %b want %b", m_word.held_a, want.held_a));
                if (m_word.held_b !== want.held_b)
                    report_failure($sformatf("held_b got %b want %b", m_word.held_b, want.held_b));
                if (m_word.activity !== want.activity)
                    report_failure($sformatf("activity got %b want %b",
                                             m_word.activity, want.activity));
                if (m_word.mode_toggle !== want.mode_toggle)
                    report_failure($sformatf("mode_toggle got %b want %b",
                                             m_word.mode_toggle, want.mode_toggle));
                if (m_word.combo_event !== want.combo_event)
                    report_failure($sformatf("combo_event got %b want %b",
                                             m_word.combo_event, want.combo_event));
                if (m_word.alarm_cancel !== want.alarm_cancel)
                    report_failure($sformatf("alarm_cancel got %b want %b",
                                             m_word.alarm_cancel, want.alarm_cancel));
                if (m_word.sleep_request !== want.sleep_request)
                    report_failure($sformatf("sleep_request got %b want %b",
                                             m_word.sleep_request, want.sleep_request));
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL two_button_debounce_gesture");
            $finish;
        end
    end

    initial begin
        reset_button_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_gestures();
        test_backpressure();
        test_random_phases();
        test_large_thresholds();
        settle_block();
        if (button_outputs_due.size() != 0) report_failure("results left pending");
        $display("covered %0d tick words, %0d results checked, %0d register writes",
                 ticks_sent, results_checked, reg_writes);
        $display("phases: defaults, gestures, receiver hold-off, four idling mixes, "
                 , "maximum thresholds");
        if (error_count == 0) begin
            $display("PASS two_button_debounce_gesture");
        end else begin
            $display("FAIL two_button_debounce_gesture");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* two_button_debounce_gesture.f */
sv/tbdg_pkg.sv
sv/tbdg_debounce.sv
sv/tbdg_gesture.sv
sv/two_button_debounce_gesture.sv
verif/tb_top.sv
